### hdl/cobs_pkg.sv
// Package for the COBS stream decoder: shared constants and beat types.
// Used by the interfaces and by every module of the decoder; depends on nothing.

package cobs_pkg;

  // Field widths fixed by the channel definitions
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 11;

  // Frame length limit; the running count saturates here
  localparam int MAX_FRAME_BYTES = 1024;
  localparam int COUNT_W         = $clog2(MAX_FRAME_BYTES + 1);

  // Code byte that opens a full group with no implied delimiter after it
  localparam logic [BYTE_W-1:0] GROUP_MAX_CODE = 8'hFF;

  // Encoded beat as held in the input register
  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              frame_last;
  } in_beat_t;

  // Decoded beat as held in the result register
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              out_valid;
    logic              frame_done;
    logic              frame_error;
    logic [LEN_W-1:0]  decoded_length;
  } out_beat_t;

endpackage

### hdl/cobs_in_if.sv
// Input channel of the COBS decoder: valid/ready handshake with an encoded byte.
// Depends on cobs_pkg for the field widths.

interface cobs_in_if;
  logic                       valid;
  logic                       ready;
  logic [cobs_pkg::BYTE_W-1:0] in_byte;
  logic                       frame_last;

  modport source (output valid, output in_byte, output frame_last, input ready);
  modport sink   (input valid, input in_byte, input frame_last, output ready);
endinterface

### hdl/cobs_out_if.sv
// Output channel of the COBS decoder: valid/ready handshake with a decoded beat.
// Depends on cobs_pkg for the field widths.

interface cobs_out_if;
  logic                        valid;
  logic                        ready;
  logic [cobs_pkg::BYTE_W-1:0] out_byte;
  logic                        out_valid;
  logic                        frame_done;
  logic                        frame_error;
  logic [cobs_pkg::LEN_W-1:0]  decoded_length;

  modport source (output valid, output out_byte, output out_valid, output frame_done,
                  output frame_error, output decoded_length, input ready);
  modport sink   (input valid, input out_byte, input out_valid, input frame_done,
                  input frame_error, input decoded_length, output ready);
endinterface

### hdl/cobs_in_reg.sv
// Input register of the COBS decoder: holds one encoded beat until the step logic takes it.
// Depends on cobs_pkg.

module cobs_in_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  cobs_pkg::in_beat_t in_beat,
  output logic               held_valid,
  output cobs_pkg::in_beat_t held_beat,
  input  logic               take
);

  // Free when empty or when the held beat leaves this cycle
  assign in_ready = !held_valid || take;

  // Occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_beat <= in_beat;
    end
  end

endmodule

### hdl/cobs_step.sv
// Decode step of the COBS decoder: group/frame state, delimiter register and result logic.
// Depends on cobs_pkg.

module cobs_step (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [cobs_pkg::BYTE_W-1:0] cfg_wdata,
  input  cobs_pkg::in_beat_t          beat,
  input  logic                        take,
  output logic                        has_result,
  output cobs_pkg::out_beat_t         result
);

  logic [cobs_pkg::BYTE_W-1:0]  delimiter_value;
  logic [cobs_pkg::BYTE_W-1:0]  bytes_left;
  logic                         last_code_was_max;
  logic                         at_frame_start;
  logic [cobs_pkg::COUNT_W-1:0] decoded_count;

  logic [cobs_pkg::BYTE_W-1:0]  bytes_left_next;
  logic                         last_code_was_max_next;
  logic                         at_frame_start_next;
  logic [cobs_pkg::COUNT_W-1:0] decoded_count_next;

  logic                         in_group;
  logic                         emit;
  logic                         frame_error;

  // Delimiter register
  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter_value <= '0;
    end else if (cfg_we) begin
      delimiter_value <= cfg_wdata;
    end
  end

  // One encoded byte: data byte inside a group, else code byte
  always_comb begin
    in_group = (bytes_left != '0);
    emit     = in_group || (!at_frame_start && !last_code_was_max);

    if (in_group) begin
      bytes_left_next        = bytes_left - 1'b1;
      last_code_was_max_next = last_code_was_max;
    end else begin
      bytes_left_next        = (beat.in_byte > 8'd1) ? beat.in_byte - 1'b1 : '0;
      last_code_was_max_next = (beat.in_byte == cobs_pkg::GROUP_MAX_CODE);
    end
    at_frame_start_next = 1'b0;

    // saturating length count
    if (emit && (decoded_count < cobs_pkg::COUNT_W'(cobs_pkg::MAX_FRAME_BYTES))) begin
      decoded_count_next = decoded_count + 1'b1;
    end else begin
      decoded_count_next = decoded_count;
    end

    frame_error = beat.frame_last && (bytes_left_next != '0);
    has_result  = emit || beat.frame_last;

    result.out_byte       = emit ? (in_group ? beat.in_byte : delimiter_value) : '0;
    result.out_valid      = emit;
    result.frame_done     = beat.frame_last;
    result.frame_error    = frame_error;
    result.decoded_length = (beat.frame_last && !frame_error) ?
                            cobs_pkg::LEN_W'(decoded_count_next) : '0;
  end

  // Group and frame state; any frame end returns to the start-of-frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left        <= '0;
      last_code_was_max <= 1'b0;
      at_frame_start    <= 1'b1;
      decoded_count     <= '0;
    end else if (take) begin
      if (beat.frame_last) begin
        bytes_left        <= '0;
        last_code_was_max <= 1'b0;
        at_frame_start    <= 1'b1;
        decoded_count     <= '0;
      end else begin
        bytes_left        <= bytes_left_next;
        last_code_was_max <= last_code_was_max_next;
        at_frame_start    <= at_frame_start_next;
        decoded_count     <= decoded_count_next;
      end
    end
  end

endmodule

### hdl/cobs_out_reg.sv
// Result register of the COBS decoder: holds one decoded beat until the sink takes it.
// Depends on cobs_pkg.

module cobs_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  cobs_pkg::out_beat_t load_beat,
  output logic                can_load,
  output logic                out_valid,
  input  logic                out_ready,
  output cobs_pkg::out_beat_t out_beat
);

  // Room when empty or when the held beat is taken this cycle
  assign can_load = !out_valid || out_ready;

  // Occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (can_load && load) begin
      out_beat <= load_beat;
    end
  end

endmodule

### hdl/cobs_stream_decoder_top.sv
// COBS stream decoder, top level. Path from input beat to result beat: input register,
// then decode step into the result register.
// Throughput: one encoded byte per cycle while the result register has room.
// Reset: rst, synchronous and active high, empties both registers, restores the
// start-of-frame state and clears the delimiter to 0.
// Depends on cobs_pkg, cobs_in_if, cobs_out_if, cobs_in_reg, cobs_step, cobs_out_reg.

module cobs_stream_decoder_top (
  input  logic                        clk,
  input  logic                        rst,
  cobs_in_if.sink                     in_ch,
  cobs_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [cobs_pkg::BYTE_W-1:0] cfg_wdata
);

  cobs_pkg::in_beat_t  in_beat;
  cobs_pkg::in_beat_t  held_beat;
  cobs_pkg::out_beat_t step_result;
  cobs_pkg::out_beat_t out_beat;
  logic                held_valid;
  logic                has_result;
  logic                can_load;
  logic                take;

  assign in_beat.in_byte    = in_ch.in_byte;
  assign in_beat.frame_last = in_ch.frame_last;

  // Held beat moves on when the result register has room
  assign take = held_valid && can_load;

  cobs_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_beat    (in_beat),
    .held_valid (held_valid),
    .held_beat  (held_beat),
    .take       (take)
  );

  cobs_step u_step (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .beat       (held_beat),
    .take       (take),
    .has_result (has_result),
    .result     (step_result)
  );

  cobs_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (take && has_result),
    .load_beat (step_result),
    .can_load  (can_load),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_beat  (out_beat)
  );

  assign out_ch.out_byte       = out_beat.out_byte;
  assign out_ch.out_valid      = out_beat.out_valid;
  assign out_ch.frame_done     = out_beat.frame_done;
  assign out_ch.frame_error    = out_beat.frame_error;
  assign out_ch.decoded_length = out_beat.decoded_length;

endmodule

### tb/sv/cobs_decode_checker.sv
// Checker for the COBS stream decoder: watches the encoded and decoded channels and the
// delimiter port, predicts every decoded beat and compares it field by field.
// Depends on cobs_pkg, cobs_in_if and cobs_out_if.

module cobs_decode_checker (
  input  logic                        clk,
  input  logic                        rst,
  cobs_in_if                          in_mon,
  cobs_out_if                         out_mon,
  input  logic                        cfg_we,
  input  logic [cobs_pkg::BYTE_W-1:0] cfg_wdata,
  output int unsigned                 fault_count,
  output int unsigned                 beats_due
);

  // Decoder state as the predictor sees it
  logic [cobs_pkg::BYTE_W-1:0] delim;
  logic [cobs_pkg::BYTE_W-1:0] group_left;
  logic                        after_full_group;
  logic                        at_start;
  logic [cobs_pkg::LEN_W-1:0]  frame_len;

  cobs_pkg::out_beat_t decoded_due[$];
  int unsigned         faults = 0;

  // Back to the start-of-frame state; the delimiter is kept
  function automatic void clear_frame();
    group_left       = '0;
    after_full_group = 1'b0;
    at_start         = 1'b1;
    frame_len        = '0;
  endfunction

  // One encoded byte in; returns 1 when it gives a decoded beat
  function automatic bit decode_byte(input logic [cobs_pkg::BYTE_W-1:0] b, input logic last,
                                     output cobs_pkg::out_beat_t res);
    bit emit;
    emit = 1'b0;
    res  = '0;
    if (group_left != 0) begin
      // data byte inside a group passes straight through
      emit         = 1'b1;
      res.out_byte = b;
      group_left   = group_left - 1'b1;
    end else begin
      // code byte: the delimiter goes out between groups, not after a full one
      if (!at_start && !after_full_group) begin
        emit         = 1'b1;
        res.out_byte = delim;
      end
      group_left       = (b > 1) ? b - 1'b1 : '0;
      after_full_group = (b == cobs_pkg::GROUP_MAX_CODE);
      at_start         = 1'b0;
    end
    if (emit && frame_len < cobs_pkg::MAX_FRAME_BYTES)
      frame_len = frame_len + 1'b1;
    res.out_valid = emit;
    if (last) begin
      res.frame_done     = 1'b1;
      res.frame_error    = (group_left != 0);
      res.decoded_length = res.frame_error ? '0 : frame_len;
      clear_frame();
    end
    return emit || last;
  endfunction

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      faults++;
      $display("%0t: %s expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  // Sample both channels at every edge
  always @(posedge clk) begin : watch
    cobs_pkg::out_beat_t res;
    cobs_pkg::out_beat_t want;
    if (rst) begin
      delim = '0;
      clear_frame();
      decoded_due.delete();
    end else begin
      if (cfg_we)
        delim = cfg_wdata;
      if (in_mon.valid && in_mon.ready) begin
        if (decode_byte(in_mon.in_byte, in_mon.frame_last, res))
          decoded_due.push_back(res);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (decoded_due.size() == 0) begin
          faults++;
          $display("%0t: beat expected none, actual byte %0h valid %0b done %0b err %0b len %0d",
                   $time, out_mon.out_byte, out_mon.out_valid, out_mon.frame_done,
                   out_mon.frame_error, out_mon.decoded_length);
        end else begin
          want = decoded_due.pop_front();
          check_field("out_byte", 32'(want.out_byte), 32'(out_mon.out_byte));
          check_field("out_valid", 32'(want.out_valid), 32'(out_mon.out_valid));
          check_field("frame_done", 32'(want.frame_done), 32'(out_mon.frame_done));
          check_field("frame_error", 32'(want.frame_error), 32'(out_mon.frame_error));
          check_field("decoded_length", 32'(want.decoded_length),
                      32'(out_mon.decoded_length));
        end
      end
    end
    fault_count <= faults;
    beats_due   <= unsigned'(decoded_due.size());
  end

endmodule

### tb/sv/cobs_stream_decoder_top_test.sv
// Top of the COBS stream decoder test: clock, reset, encoded-byte stimulus, output
// back-pressure and the verdict. Depends on cobs_pkg, both channel interfaces,
// cobs_stream_decoder_top and cobs_decode_checker.

module cobs_stream_decoder_top_test;

  typedef logic [cobs_pkg::BYTE_W-1:0] byte_t;

  localparam int unsigned HOLD_CYCLES = 300;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  byte_t       cfg_wdata;
  int unsigned fault_count;
  int unsigned beats_due;
  bit          hold_req = 1'b0;

  // Directed frames, each entry {frame_last, byte}
  logic [cobs_pkg::BYTE_W:0] directed_beats [20] = '{
    9'h101,                                 // lone empty code closes an empty frame
    9'h100,                                 // code 0 behaves the same
    9'h1FF,                                 // full-group code as last byte: open group
    9'h003, 9'h0FF, 9'h000, 9'h002, 9'h180, // data extremes, delimiter, clean close
    9'h005, 9'h011, 9'h122,                 // frame ends inside a group
    9'h002, 9'h0AA, 9'h100,                 // closing code 0 after a group
    9'h001, 9'h001, 9'h1FF,                 // empty groups, then full group left open
    9'h002, 9'h055,                         // frame left open across a register write
    9'h101
  };

  cobs_in_if  in_ch ();
  cobs_out_if out_ch ();

  cobs_stream_decoder_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  cobs_decode_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .fault_count (fault_count),
    .beats_due   (beats_due)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #(64'd6400000);
    $display("Test completed with failures");
    $finish;
  end

  // Gap length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one beat and hold it until taken
  task automatic send_beat(input byte_t b, input logic last, input bit steady);
    int unsigned gap;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.in_byte    <= b;
    in_ch.frame_last <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Stop offering, let every predicted beat drain, then allow for the pipeline
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (beats_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_delimiter(input byte_t value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random phase: mostly well-formed frames, some truncated, some noise
  task automatic run_phase(input byte_t delim_val, input int unsigned n_items,
                           input bit with_hold);
    byte_t       enc[$];
    int unsigned sent;
    int unsigned pick;
    int unsigned n;
    int unsigned len;
    int unsigned cut;
    bit          steady;
    wait_idle();
    set_delimiter(delim_val);
    if (with_hold)
      hold_req = 1'b1;
    sent = 0;
    while (sent < n_items) begin
      pick   = $urandom_range(0, 99);
      steady = ($urandom_range(0, 3) == 0);
      if (pick < 8) begin
        // noise: random bytes, random frame ends
        n = $urandom_range(1, 6);
        repeat (n) send_beat(byte_t'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                             steady);
        sent += n;
      end else begin
        enc.delete();
        repeat ($urandom_range(1, 4)) begin
          len = ($urandom_range(0, 49) == 0) ? 254 : $urandom_range(0, 12);
          if (len == 0 && $urandom_range(0, 1) == 1)
            enc.push_back(8'h00);
          else
            enc.push_back(byte_t'(len + 1));
          repeat (len) enc.push_back(byte_t'($urandom_range(0, 255)));
        end
        // truncated frame: ends early, usually inside a group
        if (pick < 20) begin
          cut = $urandom_range(1, enc.size());
          while (enc.size() > cut) void'(enc.pop_back());
        end
        foreach (enc[i]) send_beat(enc[i], i == enc.size() - 1, steady);
        sent += enc.size();
      end
    end
  endtask

  // Output side: random stalls, one long hold-off on request
  initial begin : drain
    int unsigned stall;
    out_ch.ready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        stall = pick_gap();
        if (stall != 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.in_byte    <= '0;
    in_ch.frame_last <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_delimiter(8'h00);

    // Directed frames; the register changes while the last frame is open
    foreach (directed_beats[i]) begin
      send_beat(directed_beats[i][cobs_pkg::BYTE_W-1:0], directed_beats[i][cobs_pkg::BYTE_W],
                1'b0);
      if (i == 18) begin
        wait_idle();
        set_delimiter(8'hFF);
      end
    end

    run_phase(byte_t'($urandom_range(1, 254)), 250, 1'b0);
    run_phase(8'hFF, 250, 1'b1);
    run_phase(8'h00, 255, 1'b0);
    run_phase(byte_t'($urandom_range(0, 255)), 255, 1'b0);

    wait_idle();
    if (fault_count == 0 && beats_due == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
